// ===== design/khmc_pkg.sv =====
// Package for the kettle heater mode controller.
// Holds event and mode codes, reset constants and shared structs.
// No dependencies.
package khmc_pkg;

  typedef enum logic [2:0] {
    CMD_SAMPLE     = 3'd0,
    CMD_BOIL_KEY   = 3'd1,
    CMD_WARM_KEY   = 3'd2,
    CMD_SET_BOIL   = 3'd3,
    CMD_SET_WARM   = 3'd4,
    CMD_SET_TARGET = 3'd5,
    CMD_SET_WATER  = 3'd6,
    CMD_TICK       = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_HEAT      = 2'd1,
    MODE_WARM_TAP  = 2'd2,
    MODE_WARM_PURE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    BUZZ_NONE  = 2'd0,
    BUZZ_BEEP  = 2'd1,
    BUZZ_FAULT = 2'd2,
    BUZZ_STOP  = 2'd3
  } buzz_e;

  // configuration register indexes
  localparam logic [1:0] CFG_BOIL_THRESHOLD  = 2'd0;
  localparam logic [1:0] CFG_FAULT_LIMIT     = 2'd1;
  localparam logic [1:0] CFG_HYSTERESIS_BAND = 2'd2;

  localparam logic [7:0] BOIL_THRESHOLD_RST  = 8'd97;
  localparam logic [7:0] FAULT_LIMIT_RST     = 8'd105;
  localparam logic [3:0] HYSTERESIS_BAND_RST = 4'd3;
  localparam logic [6:0] TARGET_TEMP_RST     = 7'd55;
  localparam logic [7:0] TARGET_MIN          = 8'd45;
  localparam logic [7:0] TARGET_MAX          = 8'd90;

  // drive bit positions
  localparam int DRV_RELAY  = 0;
  localparam int DRV_RED    = 1;
  localparam int DRV_ORANGE = 2;
  localparam int DRV_GREEN  = 3;

  // report mask bit positions
  localparam int REP_BOIL  = 0;
  localparam int REP_WARM  = 1;
  localparam int REP_TEMP  = 2;
  localparam int REP_FAULT = 3;

  typedef struct packed {
    logic [7:0] boil_threshold;
    logic [7:0] fault_limit;
    logic [3:0] hysteresis_band;
  } cfg_t;

  typedef struct packed {
    logic       boil_on;
    logic       warm_on;
    logic [7:0] current_temp;
    logic [6:0] target_temp;
    logic       pure_water;
    logic       fault_latched;
    mode_e      work_mode;
    logic [3:0] drive_bits;
  } state_t;

  typedef struct packed {
    logic       relay_on;
    logic       led_red;
    logic       led_orange;
    logic       led_green;
    buzz_e      buzzer_action;
    logic       fault_flag;
    mode_e      mode_now;
    logic       water_pure;
    logic       boil_enable;
    logic       warm_enable;
    logic [3:0] report_mask;
    logic [7:0] echo_value;
  } result_t;

endpackage

// ===== design/khmc_cfg.sv =====
// Configuration register file of the kettle heater mode controller.
// Depends on khmc_pkg.
module khmc_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [7:0]       cfg_wdata_i,
  output khmc_pkg::cfg_t   cfg_o
);

  khmc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        khmc_pkg::CFG_BOIL_THRESHOLD:  cfg_d.boil_threshold  = cfg_wdata_i;
        khmc_pkg::CFG_FAULT_LIMIT:     cfg_d.fault_limit     = cfg_wdata_i;
        khmc_pkg::CFG_HYSTERESIS_BAND: cfg_d.hysteresis_band = cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boil_threshold  <= khmc_pkg::BOIL_THRESHOLD_RST;
      cfg_q.fault_limit     <= khmc_pkg::FAULT_LIMIT_RST;
      cfg_q.hysteresis_band <= khmc_pkg::HYSTERESIS_BAND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/khmc_core.sv =====
// Event step logic: applies one event to the controller state and forms the result.
// Purely combinational. Depends on khmc_pkg.
module khmc_core (
  input  khmc_pkg::cfg_t    cfg_i,
  input  khmc_pkg::state_t  state_i,
  input  khmc_pkg::cmd_e    cmd_i,
  input  logic [7:0]        value_i,
  output khmc_pkg::state_t  state_o,
  output khmc_pkg::result_t res_o
);

  khmc_pkg::state_t  s;
  khmc_pkg::buzz_e   buzz;
  logic [3:0]        rep;
  logic [7:0]        echo;
  logic              nz;
  logic [8:0]        temp_plus_band;

  assign nz = (value_i != 8'd0);
  assign temp_plus_band = {1'b0, s.current_temp} + {5'd0, cfg_i.hysteresis_band};

  always_comb begin
    s    = state_i;
    buzz = khmc_pkg::BUZZ_NONE;
    rep  = 4'd0;
    echo = 8'd0;

    unique case (cmd_i)
      khmc_pkg::CMD_SAMPLE: begin
        if (s.current_temp != value_i) begin
          s.current_temp = value_i;
          rep[khmc_pkg::REP_TEMP] = 1'b1;
        end
      end
      khmc_pkg::CMD_BOIL_KEY: begin
        if (!s.fault_latched) begin
          s.boil_on = ~s.boil_on;
          s.drive_bits[khmc_pkg::DRV_RED] = s.boil_on;
          rep[khmc_pkg::REP_BOIL] = 1'b1;
          buzz = khmc_pkg::BUZZ_BEEP;
        end
      end
      khmc_pkg::CMD_WARM_KEY: begin
        if (!s.fault_latched) begin
          s.warm_on = ~s.warm_on;
          s.drive_bits[khmc_pkg::DRV_ORANGE] = s.warm_on;
          rep[khmc_pkg::REP_WARM] = 1'b1;
          buzz = khmc_pkg::BUZZ_BEEP;
        end
      end
      khmc_pkg::CMD_SET_BOIL: begin
        if (!s.fault_latched) begin
          s.boil_on = nz;
          s.drive_bits[khmc_pkg::DRV_RED] = nz;
          rep[khmc_pkg::REP_BOIL] = 1'b1;
        end
        echo = {7'd0, s.boil_on};
      end
      khmc_pkg::CMD_SET_WARM: begin
        if (!s.fault_latched) begin
          s.warm_on = nz;
          s.drive_bits[khmc_pkg::DRV_ORANGE] = nz;
          rep[khmc_pkg::REP_WARM] = 1'b1;
        end
        echo = {7'd0, s.warm_on};
      end
      khmc_pkg::CMD_SET_TARGET: begin
        if (value_i >= khmc_pkg::TARGET_MIN && value_i <= khmc_pkg::TARGET_MAX) begin
          s.target_temp = value_i[6:0];
        end
        echo = {1'b0, s.target_temp};
      end
      khmc_pkg::CMD_SET_WATER: begin
        s.pure_water = nz;
        echo = {7'd0, nz};
      end
      default: ;
    endcase

    // over-temperature fault latch and release
    if (!s.fault_latched) begin
      if (s.current_temp >= cfg_i.fault_limit) begin
        s.fault_latched = 1'b1;
        s.boil_on       = 1'b0;
        s.warm_on       = 1'b0;
        s.drive_bits    = 4'd0;
        buzz            = khmc_pkg::BUZZ_FAULT;
        rep[khmc_pkg::REP_BOIL]  = 1'b1;
        rep[khmc_pkg::REP_WARM]  = 1'b1;
        rep[khmc_pkg::REP_FAULT] = 1'b1;
      end
    end else if (s.current_temp < cfg_i.fault_limit) begin
      s.fault_latched = 1'b0;
      buzz            = khmc_pkg::BUZZ_STOP;
      rep[khmc_pkg::REP_FAULT] = 1'b1;
    end

    if (s.boil_on) begin
      s.work_mode = khmc_pkg::MODE_HEAT;
    end else if (s.warm_on) begin
      s.work_mode = s.pure_water ? khmc_pkg::MODE_WARM_PURE : khmc_pkg::MODE_WARM_TAP;
    end else begin
      s.work_mode = khmc_pkg::MODE_IDLE;
    end

    if (!s.fault_latched) begin
      unique case (s.work_mode)
        khmc_pkg::MODE_IDLE: begin
          s.drive_bits = 4'd0;
        end
        khmc_pkg::MODE_HEAT: begin
          if (s.current_temp >= cfg_i.boil_threshold) begin
            s.pure_water = 1'b1;
            s.boil_on    = 1'b0;
            rep[khmc_pkg::REP_BOIL] = 1'b1;
            s.drive_bits[khmc_pkg::DRV_RED]   = 1'b0;
            s.drive_bits[khmc_pkg::DRV_RELAY] = 1'b0;
          end else begin
            s.drive_bits[khmc_pkg::DRV_RELAY] = 1'b1;
          end
        end
        khmc_pkg::MODE_WARM_TAP: begin
          if (s.current_temp >= cfg_i.boil_threshold) begin
            s.pure_water = 1'b1;
            s.drive_bits[khmc_pkg::DRV_RELAY] = 1'b0;
          end else begin
            s.drive_bits[khmc_pkg::DRV_RELAY] = 1'b1;
          end
        end
        khmc_pkg::MODE_WARM_PURE: begin
          // hold between target minus band and target
          if (s.current_temp > {1'b0, s.target_temp}) begin
            s.drive_bits[khmc_pkg::DRV_ORANGE] = 1'b1;
            s.drive_bits[khmc_pkg::DRV_GREEN]  = 1'b0;
            s.drive_bits[khmc_pkg::DRV_RELAY]  = 1'b0;
          end else if (temp_plus_band < {2'd0, s.target_temp}) begin
            s.drive_bits[khmc_pkg::DRV_ORANGE] = 1'b1;
            s.drive_bits[khmc_pkg::DRV_RELAY]  = 1'b1;
            s.drive_bits[khmc_pkg::DRV_GREEN]  = 1'b0;
          end else begin
            s.drive_bits[khmc_pkg::DRV_GREEN]  = 1'b1;
            s.drive_bits[khmc_pkg::DRV_ORANGE] = 1'b0;
            s.drive_bits[khmc_pkg::DRV_RELAY]  = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign state_o = s;

  always_comb begin
    res_o.relay_on      = s.drive_bits[khmc_pkg::DRV_RELAY];
    res_o.led_red       = s.drive_bits[khmc_pkg::DRV_RED];
    res_o.led_orange    = s.drive_bits[khmc_pkg::DRV_ORANGE];
    res_o.led_green     = s.drive_bits[khmc_pkg::DRV_GREEN];
    res_o.buzzer_action = buzz;
    res_o.fault_flag    = s.fault_latched;
    res_o.mode_now      = s.work_mode;
    res_o.water_pure    = s.pure_water;
    res_o.boil_enable   = s.boil_on;
    res_o.warm_enable   = s.warm_on;
    res_o.report_mask   = rep;
    res_o.echo_value    = echo;
  end

endmodule

// ===== design/kettle_heater_mode_controller_top.sv =====
// Top level of the kettle heater mode controller.
// Instantiates khmc_cfg and khmc_core; depends on khmc_pkg.
//
// Takes one event item per cycle and returns one result item per event, in order.
// An accepted item is held in the input register, then its result is
// computed against the controller state in one pass and lands in the output
// register, and the rate is one item per clock while the output side keeps
// taking results. State and result update together, so a stall downstream
// holds the pipe without losing or repeating an item. Configuration writes
// take effect at the next edge and are expected only while the block is idle.
module kettle_heater_mode_controller_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       relay_on_o,
  output logic       led_red_o,
  output logic       led_orange_o,
  output logic       led_green_o,
  output logic [1:0] buzzer_action_o,
  output logic       fault_flag_o,
  output logic [1:0] mode_now_o,
  output logic       water_pure_o,
  output logic       boil_enable_o,
  output logic       warm_enable_o,
  output logic [3:0] report_mask_o,
  output logic [7:0] echo_value_o
);

  khmc_pkg::cfg_t    cfg;
  khmc_pkg::state_t  state_q, state_d;
  khmc_pkg::result_t res_d, res_q;
  khmc_pkg::cmd_e    cmd_q;
  logic [7:0]        value_q;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              adv;
  logic              in_acc;

  khmc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  khmc_core u_core (
    .cfg_i   (cfg),
    .state_i (state_q),
    .cmd_i   (cmd_q),
    .value_i (value_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // output slot free or being emptied this cycle
  assign adv        = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = in_valid_q & ~adv;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= khmc_pkg::cmd_e'(cmd_i);
      value_q <= value_i;
    end
    if (adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.boil_on       <= 1'b0;
      state_q.warm_on       <= 1'b0;
      state_q.current_temp  <= 8'd0;
      state_q.target_temp   <= khmc_pkg::TARGET_TEMP_RST;
      state_q.pure_water    <= 1'b0;
      state_q.fault_latched <= 1'b0;
      state_q.work_mode     <= khmc_pkg::MODE_IDLE;
      state_q.drive_bits    <= 4'd0;
    end else if (adv && in_valid_q) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign relay_on_o      = res_q.relay_on;
  assign led_red_o       = res_q.led_red;
  assign led_orange_o    = res_q.led_orange;
  assign led_green_o     = res_q.led_green;
  assign buzzer_action_o = res_q.buzzer_action;
  assign fault_flag_o    = res_q.fault_flag;
  assign mode_now_o      = res_q.mode_now;
  assign water_pure_o    = res_q.water_pure;
  assign boil_enable_o   = res_q.boil_enable;
  assign warm_enable_o   = res_q.warm_enable;
  assign report_mask_o   = res_q.report_mask;
  assign echo_value_o    = res_q.echo_value;

endmodule

// ===== design/khmc_chk.sv =====
// Port-level checker for the kettle heater mode controller, bound to the top level.
// Depends on khmc_pkg and kettle_heater_mode_controller_top.
module khmc_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       relay_on_o,
  input logic       led_red_o,
  input logic       led_orange_o,
  input logic       led_green_o,
  input logic [1:0] buzzer_action_o,
  input logic       fault_flag_o,
  input logic [1:0] mode_now_o,
  input logic       boil_enable_o,
  input logic       warm_enable_o,
  input logic [7:0] echo_value_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(echo_value_o) && $stable(mode_now_o)
      && $stable(buzzer_action_o))
    else $error("stalled result changed");

  // a latched fault keeps everything off and the requests cleared
  a_fault_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_flag_o |-> !relay_on_o && !led_red_o && !led_orange_o
      && !led_green_o && !boil_enable_o && !warm_enable_o
      && mode_now_o == khmc_pkg::MODE_IDLE)
    else $error("drive or request active under fault");

  // alarm codes agree with the fault flag
  a_alarm_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (buzzer_action_o != khmc_pkg::BUZZ_FAULT || fault_flag_o)
      && (buzzer_action_o != khmc_pkg::BUZZ_STOP || !fault_flag_o))
    else $error("alarm code does not match fault flag");

endmodule

bind kettle_heater_mode_controller_top khmc_chk u_khmc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .relay_on_o      (relay_on_o),
  .led_red_o       (led_red_o),
  .led_orange_o    (led_orange_o),
  .led_green_o     (led_green_o),
  .buzzer_action_o (buzzer_action_o),
  .fault_flag_o    (fault_flag_o),
  .mode_now_o      (mode_now_o),
  .boil_enable_o   (boil_enable_o),
  .warm_enable_o   (warm_enable_o),
  .echo_value_o    (echo_value_o)
);

// ===== tb/kettle_heater_mode_controller_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for kettle_heater_mode_controller_top.
// A predictor class tracks kettle state and checks each result item in order.
// Depends on khmc_pkg and the top level RTL.

class kettle_mode_predictor;
  logic [7:0]        boil_thr;
  logic [7:0]        fault_lim;
  logic [3:0]        hyst_band;
  logic              boil_on;
  logic              warm_on;
  logic              pure_water;
  logic              fault_latched;
  logic [7:0]        temp_now;
  logic [6:0]        target;
  khmc_pkg::mode_e   mode;
  logic [3:0]        drive;
  khmc_pkg::result_t pending_results[$];
  int                errors;
  int                events;
  int                results;
  int                fault_entries;
  int                fault_releases;

  function new();
    boil_thr       = khmc_pkg::BOIL_THRESHOLD_RST;
    fault_lim      = khmc_pkg::FAULT_LIMIT_RST;
    hyst_band      = khmc_pkg::HYSTERESIS_BAND_RST;
    boil_on        = 1'b0;
    warm_on        = 1'b0;
    pure_water     = 1'b0;
    fault_latched  = 1'b0;
    temp_now       = 8'd0;
    target         = khmc_pkg::TARGET_TEMP_RST;
    mode           = khmc_pkg::MODE_IDLE;
    drive          = 4'd0;
    errors         = 0;
    events         = 0;
    results        = 0;
    fault_entries  = 0;
    fault_releases = 0;
  endfunction

  function void set_cfg(logic [1:0] idx, logic [7:0] data);
    case (idx)
      khmc_pkg::CFG_BOIL_THRESHOLD:  boil_thr = data;
      khmc_pkg::CFG_FAULT_LIMIT:     fault_lim = data;
      khmc_pkg::CFG_HYSTERESIS_BAND: hyst_band = data[3:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // Accepted event item: update state and queue the result it must produce.
  function void apply_event(khmc_pkg::cmd_e cmd, logic [7:0] val);
    logic              nz;
    khmc_pkg::buzz_e   buzz;
    logic [3:0]        rep;
    logic [7:0]        echo;
    khmc_pkg::result_t r;
    nz   = (val != 8'd0);
    buzz = khmc_pkg::BUZZ_NONE;
    rep  = 4'd0;
    echo = 8'd0;
    case (cmd)
      khmc_pkg::CMD_SAMPLE: begin
        if (temp_now != val) begin
          temp_now = val;
          rep[khmc_pkg::REP_TEMP] = 1'b1;
        end
      end
      khmc_pkg::CMD_BOIL_KEY: begin
        if (!fault_latched) begin
          boil_on = !boil_on;
          drive[khmc_pkg::DRV_RED] = boil_on;
          rep[khmc_pkg::REP_BOIL] = 1'b1;
          buzz = khmc_pkg::BUZZ_BEEP;
        end
      end
      khmc_pkg::CMD_WARM_KEY: begin
        if (!fault_latched) begin
          warm_on = !warm_on;
          drive[khmc_pkg::DRV_ORANGE] = warm_on;
          rep[khmc_pkg::REP_WARM] = 1'b1;
          buzz = khmc_pkg::BUZZ_BEEP;
        end
      end
      khmc_pkg::CMD_SET_BOIL: begin
        if (!fault_latched) begin
          boil_on = nz;
          drive[khmc_pkg::DRV_RED] = nz;
          rep[khmc_pkg::REP_BOIL] = 1'b1;
        end
        echo = {7'd0, boil_on};
      end
      khmc_pkg::CMD_SET_WARM: begin
        if (!fault_latched) begin
          warm_on = nz;
          drive[khmc_pkg::DRV_ORANGE] = nz;
          rep[khmc_pkg::REP_WARM] = 1'b1;
        end
        echo = {7'd0, warm_on};
      end
      khmc_pkg::CMD_SET_TARGET: begin
        if (val >= khmc_pkg::TARGET_MIN && val <= khmc_pkg::TARGET_MAX) target = val[6:0];
        echo = {1'b0, target};
      end
      khmc_pkg::CMD_SET_WATER: begin
        pure_water = nz;
        echo = {7'd0, pure_water};
      end
      default: ;
    endcase

    if (!fault_latched) begin
      if (temp_now >= fault_lim) begin
        fault_latched = 1'b1;
        boil_on = 1'b0;
        warm_on = 1'b0;
        drive = 4'd0;
        buzz = khmc_pkg::BUZZ_FAULT;
        rep[khmc_pkg::REP_BOIL] = 1'b1;
        rep[khmc_pkg::REP_WARM] = 1'b1;
        rep[khmc_pkg::REP_FAULT] = 1'b1;
        fault_entries++;
      end
    end else if (temp_now < fault_lim) begin
      fault_latched = 1'b0;
      buzz = khmc_pkg::BUZZ_STOP;
      rep[khmc_pkg::REP_FAULT] = 1'b1;
      fault_releases++;
    end

    if (boil_on) mode = khmc_pkg::MODE_HEAT;
    else if (warm_on) mode = pure_water ? khmc_pkg::MODE_WARM_PURE : khmc_pkg::MODE_WARM_TAP;
    else mode = khmc_pkg::MODE_IDLE;

    if (!fault_latched) begin
      case (mode)
        khmc_pkg::MODE_IDLE: drive = 4'd0;
        khmc_pkg::MODE_HEAT: begin
          // boiled: water counts as pure, boil request drops, mode stays boil this item
          if (temp_now >= boil_thr) begin
            pure_water = 1'b1;
            boil_on = 1'b0;
            rep[khmc_pkg::REP_BOIL] = 1'b1;
            drive[khmc_pkg::DRV_RED] = 1'b0;
            drive[khmc_pkg::DRV_RELAY] = 1'b0;
          end else begin
            drive[khmc_pkg::DRV_RELAY] = 1'b1;
          end
        end
        khmc_pkg::MODE_WARM_TAP: begin
          if (temp_now >= boil_thr) begin
            pure_water = 1'b1;
            drive[khmc_pkg::DRV_RELAY] = 1'b0;
          end else begin
            drive[khmc_pkg::DRV_RELAY] = 1'b1;
          end
        end
        default: begin
          if (temp_now > target) begin
            drive[khmc_pkg::DRV_ORANGE] = 1'b1;
            drive[khmc_pkg::DRV_GREEN] = 1'b0;
            drive[khmc_pkg::DRV_RELAY] = 1'b0;
          end else if (int'(temp_now) + int'(hyst_band) < int'(target)) begin
            drive[khmc_pkg::DRV_ORANGE] = 1'b1;
            drive[khmc_pkg::DRV_RELAY] = 1'b1;
            drive[khmc_pkg::DRV_GREEN] = 1'b0;
          end else begin
            drive[khmc_pkg::DRV_GREEN] = 1'b1;
            drive[khmc_pkg::DRV_ORANGE] = 1'b0;
            drive[khmc_pkg::DRV_RELAY] = 1'b0;
          end
        end
      endcase
    end

    r.relay_on      = drive[khmc_pkg::DRV_RELAY];
    r.led_red       = drive[khmc_pkg::DRV_RED];
    r.led_orange    = drive[khmc_pkg::DRV_ORANGE];
    r.led_green     = drive[khmc_pkg::DRV_GREEN];
    r.buzzer_action = buzz;
    r.fault_flag    = fault_latched;
    r.mode_now      = mode;
    r.water_pure    = pure_water;
    r.boil_enable   = boil_on;
    r.warm_enable   = warm_on;
    r.report_mask   = rep;
    r.echo_value    = echo;
    pending_results.push_back(r);
    events++;
  endfunction

  function void compare_field(string field, logic [7:0] want, logic [7:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", field, want, seen);
      errors++;
    end
  endfunction

  function void compare_result(khmc_pkg::result_t seen);
    khmc_pkg::result_t want;
    results++;
    if (pending_results.size() == 0) begin
      $error("result item with no event waiting");
      errors++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("relay_on", want.relay_on, seen.relay_on);
    compare_field("led_red", want.led_red, seen.led_red);
    compare_field("led_orange", want.led_orange, seen.led_orange);
    compare_field("led_green", want.led_green, seen.led_green);
    compare_field("buzzer_action", want.buzzer_action, seen.buzzer_action);
    compare_field("fault_flag", want.fault_flag, seen.fault_flag);
    compare_field("mode_now", want.mode_now, seen.mode_now);
    compare_field("water_pure", want.water_pure, seen.water_pure);
    compare_field("boil_enable", want.boil_enable, seen.boil_enable);
    compare_field("warm_enable", want.warm_enable, seen.warm_enable);
    compare_field("report_mask", want.report_mask, seen.report_mask);
    compare_field("echo_value", want.echo_value, seen.echo_value);
  endfunction
endclass

module kettle_heater_mode_controller_top_tb;

  localparam int STUCK_LIMIT = 2000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] cmd_i;
  logic [7:0] value_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       relay_on_o;
  logic       led_red_o;
  logic       led_orange_o;
  logic       led_green_o;
  logic [1:0] buzzer_action_o;
  logic       fault_flag_o;
  logic [1:0] mode_now_o;
  logic       water_pure_o;
  logic       boil_enable_o;
  logic       warm_enable_o;
  logic [3:0] report_mask_o;
  logic [7:0] echo_value_o;

  kettle_mode_predictor sb;
  khmc_pkg::result_t seen_result;
  int send_idle_pct;
  int stall_pct;
  int walk_temp;
  int settings_done;
  int stuck_cycles;

  kettle_heater_mode_controller_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .relay_on_o     (relay_on_o),
    .led_red_o      (led_red_o),
    .led_orange_o   (led_orange_o),
    .led_green_o    (led_green_o),
    .buzzer_action_o(buzzer_action_o),
    .fault_flag_o   (fault_flag_o),
    .mode_now_o     (mode_now_o),
    .water_pure_o   (water_pure_o),
    .boil_enable_o  (boil_enable_o),
    .warm_enable_o  (warm_enable_o),
    .report_mask_o  (report_mask_o),
    .echo_value_o   (echo_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver side: random stall at the current rate
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
    end
  end

  // values read here are the ones present before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen_result.relay_on      = relay_on_o;
        seen_result.led_red       = led_red_o;
        seen_result.led_orange    = led_orange_o;
        seen_result.led_green     = led_green_o;
        seen_result.buzzer_action = khmc_pkg::buzz_e'(buzzer_action_o);
        seen_result.fault_flag    = fault_flag_o;
        seen_result.mode_now      = khmc_pkg::mode_e'(mode_now_o);
        seen_result.water_pure    = water_pure_o;
        seen_result.boil_enable   = boil_enable_o;
        seen_result.warm_enable   = warm_enable_o;
        seen_result.report_mask   = report_mask_o;
        seen_result.echo_value    = echo_value_o;
        sb.compare_result(seen_result);
      end
      if (in_valid_i && !in_stall_o) sb.apply_event(khmc_pkg::cmd_e'(cmd_i), value_i);
    end
  end

  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $error("no item moved for %0d cycles", STUCK_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Called at a clock edge; returns at the edge where the item is taken.
  task automatic send_event(khmc_pkg::cmd_e cmd, logic [7:0] val);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_cfg(idx, data);
  endtask

  task automatic apply_settings(logic [7:0] thr, logic [7:0] lim, logic [3:0] band);
    write_reg(khmc_pkg::CFG_BOIL_THRESHOLD, thr);
    write_reg(khmc_pkg::CFG_FAULT_LIMIT, lim);
    write_reg(khmc_pkg::CFG_HYSTERESIS_BAND, {4'd0, band});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_done++;
  endtask

  // Temperature ramps around target, boil point and fault limit,
  // mixed with keys and remote settings.
  task automatic run_random(int count);
    int             pick;
    khmc_pkg::cmd_e cmd;
    logic [7:0]     val;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        cmd = khmc_pkg::CMD_SAMPLE;
        pick = $urandom_range(99);
        if (pick < 70) walk_temp = walk_temp + int'($urandom_range(14)) - 6;
        else if (pick < 80) walk_temp = int'(sb.target) - int'($urandom_range(18)) + 4;
        else if (pick < 88) walk_temp = int'(sb.boil_thr) + int'($urandom_range(6)) - 3;
        else if (pick < 95) walk_temp = int'(sb.fault_lim) + int'($urandom_range(6)) - 3;
        else walk_temp = int'($urandom_range(255));
        if (walk_temp < 0) walk_temp = 0;
        if (walk_temp > 255) walk_temp = 255;
        val = 8'(walk_temp);
      end else if (pick < 48) begin
        cmd = khmc_pkg::CMD_BOIL_KEY;
        val = 8'($urandom_range(255));
      end else if (pick < 56) begin
        cmd = khmc_pkg::CMD_WARM_KEY;
        val = 8'($urandom_range(255));
      end else if (pick < 70) begin
        cmd = (pick < 63) ? khmc_pkg::CMD_SET_BOIL : khmc_pkg::CMD_SET_WARM;
        val = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
      end else if (pick < 80) begin
        cmd = khmc_pkg::CMD_SET_TARGET;
        val = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(90, 45));
      end else if (pick < 88) begin
        cmd = khmc_pkg::CMD_SET_WATER;
        val = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255));
      end else begin
        cmd = khmc_pkg::CMD_TICK;
        val = 8'($urandom_range(255));
      end
      send_event(cmd, val);
      // now and then hold off until the pipe is empty
      if ($urandom_range(99) == 0) wait_results_done();
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = khmc_pkg::CMD_SAMPLE;
    value_i = 8'd0;
    cfg_we_i = 1'b0;
    cfg_idx_i = khmc_pkg::CFG_BOIL_THRESHOLD;
    cfg_wdata_i = 8'd0;
    send_idle_pct = 0;
    stall_pct = 0;
    walk_temp = 20;
    settings_done = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass on reset settings
    send_event(khmc_pkg::CMD_TICK, 8'hFF);
    send_event(khmc_pkg::CMD_BOIL_KEY, 8'hAA);
    send_event(khmc_pkg::CMD_SAMPLE, 8'd50);
    send_event(khmc_pkg::CMD_SAMPLE, 8'd97);      // boil point reached
    send_event(khmc_pkg::CMD_SET_WATER, 8'h00);
    send_event(khmc_pkg::CMD_SAMPLE, 8'd20);
    send_event(khmc_pkg::CMD_WARM_KEY, 8'h55);    // keep-warm on tap water
    send_event(khmc_pkg::CMD_SET_WATER, 8'h01);
    send_event(khmc_pkg::CMD_SET_TARGET, 8'd44);  // below range, ignored
    send_event(khmc_pkg::CMD_SET_TARGET, 8'd91);  // above range, ignored
    send_event(khmc_pkg::CMD_SET_TARGET, 8'd90);
    send_event(khmc_pkg::CMD_SET_TARGET, 8'd45);
    send_event(khmc_pkg::CMD_SET_TARGET, 8'd70);
    send_event(khmc_pkg::CMD_SAMPLE, 8'd68);      // inside hysteresis band
    send_event(khmc_pkg::CMD_SAMPLE, 8'd80);      // above target
    send_event(khmc_pkg::CMD_SET_BOIL, 8'h80);    // nonzero counts as on
    send_event(khmc_pkg::CMD_SET_WARM, 8'h00);
    send_event(khmc_pkg::CMD_SET_BOIL, 8'h00);
    send_event(khmc_pkg::CMD_SET_WARM, 8'hFF);
    send_event(khmc_pkg::CMD_SAMPLE, 8'hFF);      // fault entry
    send_event(khmc_pkg::CMD_BOIL_KEY, 8'h00);    // ignored while faulted
    send_event(khmc_pkg::CMD_SET_WARM, 8'h01);
    send_event(khmc_pkg::CMD_SET_TARGET, 8'd60);  // still applies while faulted
    send_event(khmc_pkg::CMD_SAMPLE, 8'd104);     // fault release
    send_event(khmc_pkg::CMD_SAMPLE, 8'd0);

    for (int seg = 0; seg < 8; seg++) begin
      wait_results_done();
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 45; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      case (seg)
        0, 6: apply_settings(khmc_pkg::BOIL_THRESHOLD_RST, khmc_pkg::FAULT_LIMIT_RST,
                             khmc_pkg::HYSTERESIS_BAND_RST);
        2: apply_settings(8'd255, 8'd255, 4'd15);
        4: apply_settings(8'd0, 8'd0, 4'd0);
        default: apply_settings(8'($urandom_range(110, 85)), 8'($urandom_range(140, 95)),
                                4'($urandom_range(15)));
      endcase
      run_random((seg == 4) ? 60 : 170);
    end

    wait_results_done();
    $display("Ran %0d events, checked %0d results over %0d register settings and four idle mixes.",
             sb.events, sb.results, settings_done);
    $display("Predicted %0d fault entries and %0d fault releases.",
             sb.fault_entries, sb.fault_releases);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
